// ----- rtl/dmtc_pkg.sv -----
// ----------------------------------------------------------------------------
// dmtc_pkg
// Shared types and constants for the direct-mapped cache tag check block.
// ----------------------------------------------------------------------------
package dmtc_pkg;

   // defaults for the top-level parameters
   localparam int DEF_MAX_LINES  = 1024;
   localparam int DEF_ADDR_WIDTH = 32;

   // fixed field widths
   localparam int ADDR_W     = 32;
   localparam int CNT_W      = 32;
   localparam int OFFSET_W   = 5;
   localparam int INDEX_W    = 4;
   localparam int SHIFT_W    = 6;
   localparam int IDX_RAW_W  = 15;
   localparam int CSR_DATA_W = 32;
   localparam int CSR_ADDR_W = 3;

   // reduction of the index modulo the line count
   localparam int RECIP_SHIFT = 16;
   localparam int RECIP_W     = 17;
   localparam int LINES_W     = 17;
   localparam int PROD_W      = IDX_RAW_W + RECIP_W;
   localparam int REM_W       = LINES_W + 1;

   // register reset values
   localparam logic [OFFSET_W-1:0] OFFSET_RESET = OFFSET_W'(5);
   localparam logic [INDEX_W-1:0]  INDEX_RESET  = INDEX_W'(4);

   // register select, taken from paddr bit 2
   typedef enum logic {
      REG_OFFSET = 1'b0,
      REG_INDEX  = 1'b1
   } csr_reg_type;

   typedef enum logic [2:0] {
      ST_CLEAR,
      ST_IDLE,
      ST_QUOT,
      ST_REM,
      ST_FIX,
      ST_READ,
      ST_CHECK,
      ST_DONE
   } ctrl_state_type;

   typedef struct packed {
      logic load;
      logic quot;
      logic rem;
      logic fix;
      logic read;
      logic check;
      logic publish;
      logic clear;
   } dp_cmd_type;

   typedef struct packed {
      logic clr_last;
      logic out_free;
   } dp_status_type;

endpackage

// ----- rtl/direct_mapped_cache_tag_check.sv -----
// ----------------------------------------------------------------------------
// direct_mapped_cache_tag_check
// Direct-mapped cache hit/miss check with saturating hit and miss counts.
//
//   channel   direction   handshake             payload
//   req       in          req_valid/req_stall   req_address
//   rsp       out         rsp_valid/rsp_stall   rsp_is_hit, rsp_hit_total,
//                                               rsp_miss_total
//   csr       in          psel/penable/pready   paddr, pwdata, prdata
//
// One address at a time: split into index and tag, two multiply steps
// reduce the index modulo MAX_LINES, then a registered tag memory read and a
// compare/update step, then the word goes to the result register.
// After reset a clearing pass invalidates every line;
// req_stall stays high until it ends.
// A stalled result waits in its register; the next address is taken while it
// waits, and only that item's final hand-off waits for the register.
// ----------------------------------------------------------------------------
module direct_mapped_cache_tag_check #(
   parameter int MAX_LINES  = dmtc_pkg::DEF_MAX_LINES,
   parameter int ADDR_WIDTH = dmtc_pkg::DEF_ADDR_WIDTH
) (
   input  logic                               clock,
   input  logic                               reset,
   input  logic                               req_valid,
   output logic                               req_stall,
   input  logic [dmtc_pkg::ADDR_W-1:0]        req_address,
   output logic                               rsp_valid,
   input  logic                               rsp_stall,
   output logic                               rsp_is_hit,
   output logic [dmtc_pkg::CNT_W-1:0]         rsp_hit_total,
   output logic [dmtc_pkg::CNT_W-1:0]         rsp_miss_total,
   input  logic                               psel,
   input  logic                               penable,
   input  logic                               pwrite,
   input  logic [dmtc_pkg::CSR_ADDR_W-1:0]    paddr,
   input  logic [dmtc_pkg::CSR_DATA_W-1:0]    pwdata,
   output logic [dmtc_pkg::CSR_DATA_W-1:0]    prdata,
   output logic                               pready
);

   logic [dmtc_pkg::OFFSET_W-1:0] offset_bits;
   logic [dmtc_pkg::INDEX_W-1:0]  index_bits;
   dmtc_pkg::dp_cmd_type          cmd;
   dmtc_pkg::dp_status_type       status;

   dmtc_csr u_csr (
      .clock       (clock),
      .reset       (reset),
      .psel        (psel),
      .penable     (penable),
      .pwrite      (pwrite),
      .paddr       (paddr),
      .pwdata      (pwdata),
      .prdata      (prdata),
      .pready      (pready),
      .offset_bits (offset_bits),
      .index_bits  (index_bits)
   );

   dmtc_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .status    (status),
      .cmd       (cmd)
   );

   dmtc_datapath #(
      .MAX_LINES  (MAX_LINES),
      .ADDR_WIDTH (ADDR_WIDTH)
   ) u_datapath (
      .clock          (clock),
      .reset          (reset),
      .cmd            (cmd),
      .status         (status),
      .address        (req_address),
      .offset_bits    (offset_bits),
      .index_bits     (index_bits),
      .rsp_valid      (rsp_valid),
      .rsp_stall      (rsp_stall),
      .rsp_is_hit     (rsp_is_hit),
      .rsp_hit_total  (rsp_hit_total),
      .rsp_miss_total (rsp_miss_total)
   );

endmodule

// ----- rtl/dmtc_csr.sv -----
// ----------------------------------------------------------------------------
// dmtc_csr
// Geometry registers behind the APB-style configuration port.
// ----------------------------------------------------------------------------
module dmtc_csr (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                psel,
   input  logic                                penable,
   input  logic                                pwrite,
   input  logic [dmtc_pkg::CSR_ADDR_W-1:0]     paddr,
   input  logic [dmtc_pkg::CSR_DATA_W-1:0]     pwdata,
   output logic [dmtc_pkg::CSR_DATA_W-1:0]     prdata,
   output logic                                pready,
   output logic [dmtc_pkg::OFFSET_W-1:0]       offset_bits,
   output logic [dmtc_pkg::INDEX_W-1:0]        index_bits
);

   logic [dmtc_pkg::OFFSET_W-1:0] offset_ff, offset_in;
   logic [dmtc_pkg::INDEX_W-1:0]  index_ff, index_in;
   logic                          wr_en;
   dmtc_pkg::csr_reg_type         sel;

   assign pready = 1'b1;
   assign wr_en  = psel && penable && pwrite && pready;
   assign sel    = dmtc_pkg::csr_reg_type'(paddr[2]);

   always_comb begin
      offset_in = offset_ff;
      index_in  = index_ff;
      if (wr_en) begin
         unique case (sel)
            dmtc_pkg::REG_OFFSET: offset_in = pwdata[dmtc_pkg::OFFSET_W-1:0];
            dmtc_pkg::REG_INDEX:  index_in  = pwdata[dmtc_pkg::INDEX_W-1:0];
            default: ;
         endcase
      end
   end

   always_comb begin
      unique case (sel)
         dmtc_pkg::REG_OFFSET:
            prdata = dmtc_pkg::CSR_DATA_W'(offset_ff);
         dmtc_pkg::REG_INDEX:
            prdata = dmtc_pkg::CSR_DATA_W'(index_ff);
         default:
            prdata = '0;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         offset_ff <= dmtc_pkg::OFFSET_RESET;
         index_ff  <= dmtc_pkg::INDEX_RESET;
      end else begin
         offset_ff <= offset_in;
         index_ff  <= index_in;
      end
   end

   assign offset_bits = offset_ff;
   assign index_bits  = index_ff;

endmodule

// ----- rtl/dmtc_ctrl.sv -----
// ----------------------------------------------------------------------------
// dmtc_ctrl
// Sequencer: clearing pass after reset, then one lookup at a time.
// ----------------------------------------------------------------------------
module dmtc_ctrl (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    req_valid,
   output logic                    req_stall,
   input  dmtc_pkg::dp_status_type status,
   output dmtc_pkg::dp_cmd_type    cmd
);

   dmtc_pkg::ctrl_state_type state_ff, state_in;

   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         dmtc_pkg::ST_CLEAR: if (status.clr_last) state_in = dmtc_pkg::ST_IDLE;
         dmtc_pkg::ST_IDLE:  if (req_valid) state_in = dmtc_pkg::ST_QUOT;
         dmtc_pkg::ST_QUOT:  state_in = dmtc_pkg::ST_REM;
         dmtc_pkg::ST_REM:   state_in = dmtc_pkg::ST_FIX;
         dmtc_pkg::ST_FIX:   state_in = dmtc_pkg::ST_READ;
         dmtc_pkg::ST_READ:  state_in = dmtc_pkg::ST_CHECK;
         dmtc_pkg::ST_CHECK: state_in = dmtc_pkg::ST_DONE;
         dmtc_pkg::ST_DONE:  if (status.out_free) state_in = dmtc_pkg::ST_IDLE;
         default:            state_in = dmtc_pkg::ST_CLEAR;
      endcase
   end

   always_comb begin
      cmd       = '0;
      req_stall = 1'b1;
      unique case (state_ff)
         dmtc_pkg::ST_CLEAR: cmd.clear = 1'b1;
         dmtc_pkg::ST_IDLE: begin
            req_stall = 1'b0;
            cmd.load  = req_valid;
         end
         dmtc_pkg::ST_QUOT:  cmd.quot    = 1'b1;
         dmtc_pkg::ST_REM:   cmd.rem     = 1'b1;
         dmtc_pkg::ST_FIX:   cmd.fix     = 1'b1;
         dmtc_pkg::ST_READ:  cmd.read    = 1'b1;
         dmtc_pkg::ST_CHECK: cmd.check   = 1'b1;
         dmtc_pkg::ST_DONE:  cmd.publish = status.out_free;
         default: ;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= dmtc_pkg::ST_CLEAR;
      end else begin
         state_ff <= state_in;
      end
   end

endmodule

// ----- rtl/dmtc_datapath.sv -----
// ----------------------------------------------------------------------------
// dmtc_datapath
// Index and tag split, index reduction, tag memory, counters, result register.
// ----------------------------------------------------------------------------
module dmtc_datapath #(
   parameter int MAX_LINES  = dmtc_pkg::DEF_MAX_LINES,
   parameter int ADDR_WIDTH = dmtc_pkg::DEF_ADDR_WIDTH
) (
   input  logic                              clock,
   input  logic                              reset,
   input  dmtc_pkg::dp_cmd_type              cmd,
   output dmtc_pkg::dp_status_type           status,
   input  logic [dmtc_pkg::ADDR_W-1:0]       address,
   input  logic [dmtc_pkg::OFFSET_W-1:0]     offset_bits,
   input  logic [dmtc_pkg::INDEX_W-1:0]      index_bits,
   output logic                              rsp_valid,
   input  logic                              rsp_stall,
   output logic                              rsp_is_hit,
   output logic [dmtc_pkg::CNT_W-1:0]        rsp_hit_total,
   output logic [dmtc_pkg::CNT_W-1:0]        rsp_miss_total
);

   localparam int AW     = (ADDR_WIDTH < dmtc_pkg::ADDR_W) ? ADDR_WIDTH : dmtc_pkg::ADDR_W;
   localparam int TAG_W  = AW;
   localparam int IDXW   = dmtc_pkg::IDX_RAW_W;
   localparam int SLOT_W = (MAX_LINES > 1) ? $clog2(MAX_LINES) : 1;
   localparam logic [dmtc_pkg::RECIP_W-1:0] RECIP =
      dmtc_pkg::RECIP_W'((1 << dmtc_pkg::RECIP_SHIFT) / MAX_LINES);
   localparam logic [dmtc_pkg::LINES_W-1:0] LINES = dmtc_pkg::LINES_W'(MAX_LINES);

   // index and tag split
   logic [AW-1:0]                addr_m;
   logic [AW-1:0]                idx_sh;
   logic [AW+IDXW-1:0]           idx_ext;
   logic [IDXW-1:0]              imask;
   logic [dmtc_pkg::SHIFT_W-1:0] tag_shift;
   logic [IDXW-1:0]              idx_ff;
   logic [TAG_W-1:0]             tag_ff;

   // index modulo the line count: reciprocal estimate, then one correction
   logic [dmtc_pkg::PROD_W-1:0]  prod_ff;
   logic [dmtc_pkg::PROD_W-1:0]  qm;
   logic [dmtc_pkg::PROD_W-1:0]  diff;
   logic [dmtc_pkg::REM_W-1:0]   rem_ff;
   logic [dmtc_pkg::REM_W-1:0]   rem_fix;
   logic [SLOT_W-1:0]            slot_ff;

   // tag memory, valid bit on top
   logic [TAG_W:0]               mem [MAX_LINES];
   logic [TAG_W:0]               rd_ff;
   logic                         mem_we;
   logic [SLOT_W-1:0]            mem_waddr;
   logic [TAG_W:0]               mem_wdata;
   logic [SLOT_W-1:0]            clr_ff;
   logic                         hit;

   logic                         hit_ff;
   logic [dmtc_pkg::CNT_W-1:0]   hit_cnt_ff, hit_cnt_in;
   logic [dmtc_pkg::CNT_W-1:0]   miss_cnt_ff, miss_cnt_in;
   logic                         rsp_valid_ff, rsp_valid_in;
   logic                         rsp_is_hit_ff;
   logic [dmtc_pkg::CNT_W-1:0]   rsp_hit_ff;
   logic [dmtc_pkg::CNT_W-1:0]   rsp_miss_ff;

   assign addr_m    = address[AW-1:0];
   assign idx_sh    = addr_m >> offset_bits;
   assign idx_ext   = {{IDXW{1'b0}}, idx_sh};
   assign imask     = ~({IDXW{1'b1}} << index_bits);
   assign tag_shift = dmtc_pkg::SHIFT_W'(offset_bits) + dmtc_pkg::SHIFT_W'(index_bits);

   assign qm      = dmtc_pkg::PROD_W'(prod_ff[dmtc_pkg::RECIP_SHIFT +: IDXW] * LINES);
   assign diff    = dmtc_pkg::PROD_W'(idx_ff) - qm;
   assign rem_fix = (rem_ff >= dmtc_pkg::REM_W'(LINES)) ?
                    (rem_ff - dmtc_pkg::REM_W'(LINES)) : rem_ff;

   assign hit = rd_ff[TAG_W] && (rd_ff[TAG_W-1:0] == tag_ff);

   always_ff @(posedge clock) begin
      if (cmd.load) begin
         idx_ff <= idx_ext[IDXW-1:0] & imask;
         tag_ff <= addr_m >> tag_shift;
      end
      if (cmd.quot) begin
         prod_ff <= dmtc_pkg::PROD_W'(idx_ff * RECIP);
      end
      if (cmd.rem) begin
         rem_ff <= diff[dmtc_pkg::REM_W-1:0];
      end
      if (cmd.fix) begin
         slot_ff <= rem_fix[SLOT_W-1:0];
      end
      if (cmd.check) begin
         hit_ff <= hit;
      end
   end

   always_comb begin
      mem_we    = 1'b0;
      mem_waddr = slot_ff;
      mem_wdata = {1'b1, tag_ff};
      if (cmd.clear) begin
         mem_we    = 1'b1;
         mem_waddr = clr_ff;
         mem_wdata = '0;
      end else if (cmd.check && !hit) begin
         mem_we = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (mem_we) begin
         mem[mem_waddr] <= mem_wdata;
      end
      if (cmd.read) begin
         rd_ff <= mem[slot_ff];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         clr_ff <= '0;
      end else if (cmd.clear) begin
         clr_ff <= clr_ff + SLOT_W'(1);
      end
   end

   // saturating counters
   always_comb begin
      hit_cnt_in  = hit_cnt_ff;
      miss_cnt_in = miss_cnt_ff;
      if (cmd.check) begin
         if (hit) begin
            if (hit_cnt_ff != '1) hit_cnt_in = hit_cnt_ff + dmtc_pkg::CNT_W'(1);
         end else begin
            if (miss_cnt_ff != '1) miss_cnt_in = miss_cnt_ff + dmtc_pkg::CNT_W'(1);
         end
      end
   end

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (cmd.publish) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_valid_ff && !rsp_stall) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         hit_cnt_ff   <= '0;
         miss_cnt_ff  <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         hit_cnt_ff   <= hit_cnt_in;
         miss_cnt_ff  <= miss_cnt_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.publish) begin
         rsp_is_hit_ff <= hit_ff;
         rsp_hit_ff    <= hit_cnt_ff;
         rsp_miss_ff   <= miss_cnt_ff;
      end
   end

   assign status.clr_last = (clr_ff == SLOT_W'(MAX_LINES - 1));
   assign status.out_free = !rsp_valid_ff || !rsp_stall;

   assign rsp_valid      = rsp_valid_ff;
   assign rsp_is_hit     = rsp_is_hit_ff;
   assign rsp_hit_total  = rsp_hit_ff;
   assign rsp_miss_total = rsp_miss_ff;

   // reduced index always lands inside the store
   assert property (@(posedge clock) disable iff (reset)
      cmd.fix |=> (32'(slot_ff) < MAX_LINES))
      else $error("slot beyond line count");

   // hit and miss counts never move together
   assert property (@(posedge clock) disable iff (reset)
      !((hit_cnt_ff != $past(hit_cnt_ff)) && (miss_cnt_ff != $past(miss_cnt_ff))))
      else $error("both counters changed");

   // counts move only after a tag check
   assert property (@(posedge clock) disable iff (reset)
      ((hit_cnt_ff != $past(hit_cnt_ff)) || (miss_cnt_ff != $past(miss_cnt_ff)))
      |-> $past(cmd.check))
      else $error("counter changed outside check");

   // a new word never overwrites one still waiting
   assert property (@(posedge clock) disable iff (reset)
      cmd.publish |-> (!rsp_valid_ff || !rsp_stall))
      else $error("result register overrun");

endmodule
